// ===== design/umon_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the cache utility partition monitor.
package umon_pkg;

  localparam int ASSOC      = 16;
  localparam int NUM_STACKS = 32;
  localparam int APPS       = 2;

  localparam int TAG_W  = 48;
  localparam int SET_W  = 10;
  localparam int CORE_W = 8;
  localparam int SW_W   = 11;
  localparam int POL_W  = 2;
  localparam int CPA_W  = 8;
  localparam int CNT_W  = 32;
  localparam int POS_W  = 4;
  localparam int WAY_W  = 5;
  localparam int STK_W  = $clog2(NUM_STACKS);
  localparam int ROW_W  = $clog2(NUM_STACKS * APPS);
  localparam int ROWS   = NUM_STACKS * APPS;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ACCESS = 2'd0,
    REQ_RECOMP = 2'd1,
    REQ_EPOCH  = 2'd2
  } req_kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPA      = 2'd2;

  // Epoch reset policies
  localparam logic [POL_W-1:0] POL_HALVE = 2'd0;
  localparam logic [POL_W-1:0] POL_CLEAR = 2'd1;

  // One sampled LRU stack: entry 0 is most recent
  typedef struct packed {
    logic [ASSOC-1:0]            valid;
    logic [ASSOC-1:0][TAG_W-1:0] tags;
  } row_t;

endpackage

// ===== design/umon_req_if.sv =====
`timescale 1ns / 1ps
// Request channel interface.
interface umon_req_if;
  import umon_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [CORE_W-1:0] core_id;
  logic [SET_W-1:0]  set_index;
  logic [TAG_W-1:0]  tag;

  modport source (output valid, req_type, core_id, set_index, tag, input ready);
  modport sink   (input valid, req_type, core_id, set_index, tag, output ready);
endinterface

// ===== design/umon_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel interface.
interface umon_rsp_if;
  import umon_pkg::*;
  logic             valid;
  logic             ready;
  logic             sampled;
  logic             hit;
  logic [POS_W-1:0] hit_position;
  logic [WAY_W-1:0] ways_app0;
  logic [WAY_W-1:0] ways_app1;

  modport source (output valid, sampled, hit, hit_position, ways_app0, ways_app1,
                  input ready);
  modport sink   (input valid, sampled, hit, hit_position, ways_app0, ways_app1,
                  output ready);
endinterface

// ===== design/umon_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the set sampling check.
module umon_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [umon_pkg::SET_W-1:0] num,
  input  logic [umon_pkg::SW_W-1:0]  den,
  output logic                      done,
  output logic [umon_pkg::SET_W-1:0] quo,
  output logic                      rem_zero
);
  import umon_pkg::*;

  localparam int CW = $clog2(SET_W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SW_W-1:0]  rem;
  logic [SET_W-1:0] num_sh;
  logic [SW_W:0]    trial;
  logic             ge;
  logic [SW_W:0]    diff;
  logic [SW_W-1:0]  rem_next;

  // Shift in the next dividend bit and try to subtract
  always_comb begin
    trial = {rem, num_sh[SET_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
    rem_next = ge ? diff[SW_W-1:0] : trial[SW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        num_sh <= num;
        quo    <= '0;
      end else if (busy) begin
        rem    <= rem_next;
        quo    <= {quo[SET_W-2:0], ge};
        num_sh <= num_sh << 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CW'(SET_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_zero = (rem == '0);
endmodule

// ===== design/cache_utility_partition_monitor_top.sv =====
`timescale 1ns / 1ps
// Utility monitor: sampled LRU stacks, hit counters and way partition search.
// Sequence: a sampled access runs the set divider, then the stack read and update; a set
//   rejected by the divider skips the stack; recompute scans splits; others go to the result.
// Throughput: one transaction at a time; next request taken once the result is posted.
// Reset: synchronous; clears stack row valid flags, counters, config to defaults,
//   split to ASSOC/2 each. No clearing pass: unwritten stack rows read as empty.
module cache_utility_partition_monitor_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [umon_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [umon_pkg::CFG_DATA_W-1:0]  cfg_data,
  umon_req_if.sink                         req,
  umon_rsp_if.source                       rsp
);
  import umon_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_CMP, S_SCAN, S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [SW_W-1:0]  sampling_width;
  logic [POL_W-1:0] reset_policy;
  logic [CPA_W-1:0] cores_per_app;

  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_width <= SW_W'(32);
      reset_policy   <= POL_HALVE;
      cores_per_app  <= CPA_W'(15);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLING: sampling_width <= cfg_data;
        CFG_POLICY:   reset_policy   <= cfg_data[POL_W-1:0];
        CFG_CPA:      cores_per_app  <= cfg_data[CPA_W-1:0];
        default: ;
      endcase
    end
  end

  // Application id from core id: app 0 below cpa, app 1 below 2*cpa
  logic             app_ok;
  logic             app_in;
  logic [CPA_W:0]   cpa2;
  always_comb begin
    cpa2   = {cores_per_app, 1'b0};
    app_in = {1'b0, req.core_id} >= {1'b0, cores_per_app};
    app_ok = (cores_per_app != '0) && ({1'b0, req.core_id} < cpa2);
  end

  logic accept;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Set divider
  logic             div_start;
  logic             div_done;
  logic [SET_W-1:0] div_quo;
  logic             div_rem_zero;
  assign div_start = accept && (req.req_type == REQ_ACCESS) &&
                     (sampling_width != '0) && app_ok;

  umon_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (req.set_index),
    .den      (sampling_width),
    .done     (div_done),
    .quo      (div_quo),
    .rem_zero (div_rem_zero)
  );

  // Stack memory, one row per sampled set and application
  row_t             stack_mem [ROWS];
  logic [ROWS-1:0]  row_written;
  logic [ROW_W-1:0] row;
  row_t             rd_row;
  row_t             wr_row;
  logic             mem_we;
  logic             row_ok;

  assign mem_we = (state == S_CMP);

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[row] <= wr_row;
    rd_row <= stack_mem[row];
  end

  // Request latches
  logic [TAG_W-1:0] tag_q;
  logic             app_q;

  // Hit counters and partition
  logic [APPS-1:0][ASSOC-1:0][CNT_W-1:0] cnt;
  logic [ASSOC-2:0][CNT_W:0]             sums;
  logic [CNT_W:0]                        best;
  logic [WAY_W-1:0]                      best_w0;
  logic [POS_W-1:0]                      scan_j;
  logic [WAY_W-1:0]                      ways0;
  logic [WAY_W-1:0]                      ways1;
  logic                                  res_sampled;
  logic                                  res_hit;
  logic [POS_W-1:0]                      res_pos;

  // Tag compare and move-to-front
  logic [ASSOC-1:0] vld;
  logic [ASSOC-1:0] match;
  logic             found;
  logic [POS_W-1:0] hit_p;
  logic [POS_W-1:0] inv_p;
  logic [POS_W-1:0] ins_q;

  always_comb begin
    vld   = row_ok ? rd_row.valid : '0;
    found = 1'b0;
    hit_p = '0;
    inv_p = POS_W'(ASSOC - 1);
    for (int i = 0; i < ASSOC; i++) begin
      match[i] = vld[i] && (rd_row.tags[i] == tag_q);
    end
    for (int i = ASSOC - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        hit_p = POS_W'(i);
      end
      if (!vld[i]) begin
        inv_p   = POS_W'(i);
      end
    end
    ins_q = found ? hit_p : inv_p;
    for (int i = 0; i < ASSOC; i++) begin
      if (i == 0) begin
        wr_row.tags[i]  = tag_q;
        wr_row.valid[i] = 1'b1;
      end else if (POS_W'(i) <= ins_q) begin
        wr_row.tags[i]  = rd_row.tags[i-1];
        wr_row.valid[i] = vld[i-1];
      end else begin
        wr_row.tags[i]  = rd_row.tags[i];
        wr_row.valid[i] = vld[i];
      end
    end
  end

  // Scan step: compare the head sum against the best so far
  logic             scan_better;
  logic [WAY_W-1:0] scan_w0;
  assign scan_better = sums[0] > best;
  assign scan_w0     = {1'b0, scan_j} + 1'b1;

  logic out_free;
  assign out_free = !rsp.valid || rsp.ready;

  // Control, counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      row_written <= '0;
      cnt         <= '0;
      ways0       <= WAY_W'(ASSOC / 2);
      ways1       <= WAY_W'(ASSOC / 2);
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.ready && !(state == S_DONE && out_free)) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_sampled <= 1'b0;
            res_hit     <= 1'b0;
            res_pos     <= '0;
            tag_q       <= req.tag;
            app_q       <= app_in;
            case (req.req_type)
              REQ_ACCESS: state <= div_start ? S_DIV : S_DONE;
              REQ_RECOMP: begin
                for (int i = 0; i < ASSOC - 1; i++) begin
                  sums[i] <= {1'b0, cnt[0][i]} + {1'b0, cnt[1][ASSOC-2-i]};
                end
                best    <= '0;
                best_w0 <= '0;
                scan_j  <= '0;
                state   <= S_SCAN;
              end
              REQ_EPOCH: begin
                for (int a = 0; a < APPS; a++) begin
                  for (int i = 0; i < ASSOC; i++) begin
                    if (reset_policy == POL_HALVE) cnt[a][i] <= cnt[a][i] >> 1;
                    else if (reset_policy == POL_CLEAR) cnt[a][i] <= '0;
                  end
                end
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_rem_zero && (div_quo < SET_W'(NUM_STACKS))) begin
              row   <= {div_quo[STK_W-1:0], app_q};
              state <= S_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RD: begin
          row_ok <= row_written[row];
          state  <= S_CMP;
        end
        S_CMP: begin
          row_written[row] <= 1'b1;
          res_sampled      <= 1'b1;
          res_hit          <= found;
          res_pos          <= found ? hit_p : '0;
          for (int a = 0; a < APPS; a++) begin
            for (int i = 0; i < ASSOC; i++) begin
              if (found && (a == int'(app_q)) && (POS_W'(i) >= hit_p) &&
                  (cnt[a][i] != '1)) begin
                cnt[a][i] <= cnt[a][i] + 1'b1;
              end
            end
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          for (int i = 0; i < ASSOC - 2; i++) sums[i] <= sums[i+1];
          sums[ASSOC-2] <= '0;
          if (scan_better) begin
            best    <= sums[0];
            best_w0 <= scan_w0;
          end
          scan_j <= scan_j + 1'b1;
          if (scan_j == POS_W'(ASSOC - 2)) begin
            if (scan_better) begin
              ways0 <= scan_w0;
              ways1 <= WAY_W'(ASSOC) - scan_w0;
            end else if (best == '0) begin
              ways0 <= WAY_W'(ASSOC / 2);
              ways1 <= WAY_W'(ASSOC / 2);
            end else begin
              ways0 <= best_w0;
              ways1 <= WAY_W'(ASSOC) - best_w0;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.sampled      <= res_sampled;
            rsp.hit          <= res_hit;
            rsp.hit_position <= res_pos;
            rsp.ways_app0    <= ways0;
            rsp.ways_app1    <= ways1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/umon_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the utility monitor, bound to the top level.
module umon_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_sampled,
  input logic                       rsp_hit,
  input logic [umon_pkg::POS_W-1:0] rsp_pos,
  input logic [umon_pkg::WAY_W-1:0] rsp_w0,
  input logic [umon_pkg::WAY_W-1:0] rsp_w1
);
  import umon_pkg::*;

  // A hit can only come from a sampled stack
  a_hit_sampled: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> rsp_sampled) else $error("hit without sample");

  // Position is zero on a miss
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_pos == '0) else $error("position on miss");

  // The split always covers every way
  a_split_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (6'(rsp_w0) + 6'(rsp_w1)) == 6'(ASSOC))
    else $error("split does not cover all ways");

  // One request at a time: busy right after a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("request taken while busy");
endmodule

bind cache_utility_partition_monitor_top umon_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_sampled (rsp.sampled),
  .rsp_hit     (rsp.hit),
  .rsp_pos     (rsp.hit_position),
  .rsp_w0      (rsp.ways_app0),
  .rsp_w1      (rsp.ways_app1)
);
